// ===== sv/rblf_pkg.sv =====
// rblf_pkg: sizes, register indexes and the stored cell word of the basin label fill
// no dependencies; imported by raster_basin_label_fill
package rblf_pkg;

    // raster limits
    localparam int MAX_ROWS = 512;
    localparam int MAX_COLS = 512;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

    // widths
    localparam int LABEL_W = 32;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W = $clog2(MAX_COLS + 1);
    localparam int SIZE_W = 10;
    localparam int PASS_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // register reset values, already clamped to the raster limits
    localparam int RESET_ROWS_RAW = 512;
    localparam int RESET_COLS_RAW = 512;
    localparam int RESET_ROWS = (RESET_ROWS_RAW > MAX_ROWS) ? MAX_ROWS : RESET_ROWS_RAW;
    localparam int RESET_COLS = (RESET_COLS_RAW > MAX_COLS) ? MAX_COLS : RESET_COLS_RAW;
    localparam int RESET_PASSES = 1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS   = 2'd0,
        CFG_NUM_COLS   = 2'd1,
        CFG_NUM_PASSES = 2'd2
    } cfg_index_t;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // one memory entry
    typedef struct packed {
        logic               ridge;
        logic [LABEL_W-1:0] label;
    } cell_word_t;

endpackage

// ===== sv/raster_basin_label_fill.sv =====
// raster_basin_label_fill: raster load, ridge masking, forward/reverse label sweeps, readout
// depends on rblf_pkg (sizes, register indexes, cell word)
//
//  channel  | signals                                   | direction | handshake
//  ---------+-------------------------------------------+-----------+----------------------
//  command  | start, busy, cmd, cell_label, cell_ridge  | in        | start && !busy
//  result   | result_valid, out_label, out_last         | out       | one-cycle strobe
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in        | cfg_valid && cfg_ready
//
// a load or read beat is accepted whenever start && !busy; a read beat shows its result
// in the cycle after it is accepted. after the last load beat busy stays high while the
// sweeps run: each visited cell goes through ST_UP, ST_SIDE and ST_WB (three reads through
// the single memory read port), each sweep opens with ST_CEN, and the fill stops early
// after a sweep pair that changes no label. ridge cells are stored with a cleared label,
// so no clearing pass follows the load. reset and a write to rows, cols or passes put the
// block back to loading at cell 0. the result side cannot stall; cfg_ready is always high.
module raster_basin_label_fill
    import rblf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic signed [LABEL_W-1:0]   cell_label,
    input  logic                        cell_ridge,
    output logic                        result_valid,
    output logic signed [LABEL_W-1:0]   out_label,
    output logic                        out_last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    typedef enum logic [5:0] {
        ST_LOAD = 6'b000001,
        ST_CEN  = 6'b000010,
        ST_UP   = 6'b000100,
        ST_SIDE = 6'b001000,
        ST_WB   = 6'b010000,
        ST_READ = 6'b100000
    } state_t;

    // label and ridge memory
    cell_word_t mem [STORE_DEPTH];

    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   rows_reg, rows_next;
    logic [COL_W-1:0]   cols_reg, cols_next;
    logic [PASS_W-1:0]  passes_reg, passes_next;
    logic [ROW_W-1:0]   ld_row_reg, ld_row_next;
    logic [COL_W-1:0]   ld_col_reg, ld_col_next;
    logic [ADDR_W-1:0]  ld_addr_reg, ld_addr_next;
    logic [ROW_W-1:0]   rd_row_reg, rd_row_next;
    logic [COL_W-1:0]   rd_col_reg, rd_col_next;
    logic [ADDR_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [ROW_W-1:0]   sw_row_reg, sw_row_next;
    logic [COL_W-1:0]   sw_col_reg, sw_col_next;
    logic [ADDR_W-1:0]  sw_addr_reg, sw_addr_next;
    logic               rev_reg, rev_next;
    logic               changed_reg, changed_next;
    logic [PASS_W-1:0]  pass_left_reg, pass_left_next;
    logic               result_valid_reg, result_valid_next;
    logic               out_last_reg, out_last_next;
    cell_word_t         center_reg, n1_reg, rd_data_reg;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    cell_word_t         mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;

    logic               accept, cfg_fire;
    logic               fwd_ok, rev_ok;
    logic [ADDR_W-1:0]  cols_ext, fwd_start_addr, n1_addr, n2_addr;
    logic               ld_last, rd_last;
    logic               dst_ok, q1, q2, wb_change;
    logic               col_end, row_end;
    logic [ROW_W-1:0]   sw_row_step;
    logic [COL_W-1:0]   sw_col_step;
    logic [ADDR_W-1:0]  sw_addr_step;
    logic [ROW_W-1:0]   size_rows;
    logic [COL_W-1:0]   size_cols;

    assign busy      = !(state_reg == ST_LOAD || state_reg == ST_READ);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign result_valid = result_valid_reg;
    assign out_label    = $signed(rd_data_reg.label);
    assign out_last     = out_last_reg;

    // clamp a written size into 1..max
    always_comb
    begin
        if (cfg_data[SIZE_W-1:0] == '0)
            size_rows = ROW_W'(1);
        else if (32'(cfg_data[SIZE_W-1:0]) > 32'(MAX_ROWS))
            size_rows = ROW_W'(MAX_ROWS);
        else
            size_rows = ROW_W'(cfg_data[SIZE_W-1:0]);

        if (cfg_data[SIZE_W-1:0] == '0)
            size_cols = COL_W'(1);
        else if (32'(cfg_data[SIZE_W-1:0]) > 32'(MAX_COLS))
            size_cols = COL_W'(MAX_COLS);
        else
            size_cols = COL_W'(cfg_data[SIZE_W-1:0]);
    end

    // sweep geometry
    assign fwd_ok         = (rows_reg >= ROW_W'(3)) && (cols_reg >= COL_W'(3));
    assign rev_ok         = (rows_reg >= ROW_W'(5)) && (cols_reg >= COL_W'(5));
    assign cols_ext       = ADDR_W'(cols_reg);
    assign fwd_start_addr = cols_ext + ADDR_W'(1);
    assign n1_addr        = rev_reg ? (sw_addr_reg + cols_ext) : (sw_addr_reg - cols_ext);
    assign n2_addr        = rev_reg ? (sw_addr_reg + ADDR_W'(1)) : (sw_addr_reg - ADDR_W'(1));

    // raster position ends
    assign ld_last = (ld_row_reg == rows_reg - ROW_W'(1)) && (ld_col_reg == cols_reg - COL_W'(1));
    assign rd_last = (rd_row_reg == rows_reg - ROW_W'(1)) && (rd_col_reg == cols_reg - COL_W'(1));

    // copy decision: the side neighbor overrides the row neighbor
    assign dst_ok    = (center_reg.label == '0) && !center_reg.ridge;
    assign q1        = (n1_reg.label != '0) && !n1_reg.ridge;
    assign q2        = (rd_data_reg.label != '0) && !rd_data_reg.ridge;
    assign wb_change = dst_ok && (q1 || q2);

    // next cell of the current sweep
    always_comb
    begin
        if (rev_reg)
        begin
            col_end = (sw_col_reg == COL_W'(2));
            row_end = (sw_row_reg == ROW_W'(2));
        end
        else
        begin
            col_end = (sw_col_reg == cols_reg - COL_W'(2));
            row_end = (sw_row_reg == rows_reg - ROW_W'(2));
        end

        if (col_end)
        begin
            if (rev_reg)
            begin
                sw_col_step  = cols_reg - COL_W'(3);
                sw_row_step  = sw_row_reg - ROW_W'(1);
                sw_addr_step = sw_addr_reg - ADDR_W'(5);
            end
            else
            begin
                sw_col_step  = COL_W'(1);
                sw_row_step  = sw_row_reg + ROW_W'(1);
                sw_addr_step = sw_addr_reg + ADDR_W'(3);
            end
        end
        else
        begin
            sw_row_step = sw_row_reg;
            if (rev_reg)
            begin
                sw_col_step  = sw_col_reg - COL_W'(1);
                sw_addr_step = sw_addr_reg - ADDR_W'(1);
            end
            else
            begin
                sw_col_step  = sw_col_reg + COL_W'(1);
                sw_addr_step = sw_addr_reg + ADDR_W'(1);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        rows_next         = rows_reg;
        cols_next         = cols_reg;
        passes_next       = passes_reg;
        ld_row_next       = ld_row_reg;
        ld_col_next       = ld_col_reg;
        ld_addr_next      = ld_addr_reg;
        rd_row_next       = rd_row_reg;
        rd_col_next       = rd_col_reg;
        rd_addr_next      = rd_addr_reg;
        sw_row_next       = sw_row_reg;
        sw_col_next       = sw_col_reg;
        sw_addr_next      = sw_addr_reg;
        rev_next          = rev_reg;
        changed_next      = changed_reg;
        pass_left_next    = pass_left_reg;
        result_valid_next = 1'b0;
        out_last_next     = out_last_reg;
        mem_we            = 1'b0;
        mem_waddr         = ld_addr_reg;
        mem_wdata         = '{ridge: cell_ridge,
                               label: cell_ridge ? '0 : LABEL_W'(cell_label)};
        mem_raddr         = sw_addr_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept && cmd == CMD_LOAD)
                begin
                    mem_we = 1'b1;
                    if (ld_last)
                    begin
                        ld_row_next  = '0;
                        ld_col_next  = '0;
                        ld_addr_next = '0;
                        rd_row_next  = '0;
                        rd_col_next  = '0;
                        rd_addr_next = '0;
                        if (passes_reg == '0 || !fwd_ok)
                            state_next = ST_READ;
                        else
                        begin
                            pass_left_next = passes_reg;
                            changed_next   = 1'b0;
                            rev_next       = 1'b0;
                            sw_row_next    = ROW_W'(1);
                            sw_col_next    = COL_W'(1);
                            sw_addr_next   = fwd_start_addr;
                            state_next     = ST_CEN;
                        end
                    end
                    else
                    begin
                        ld_addr_next = ld_addr_reg + ADDR_W'(1);
                        if (ld_col_reg == cols_reg - COL_W'(1))
                        begin
                            ld_col_next = '0;
                            ld_row_next = ld_row_reg + ROW_W'(1);
                        end
                        else
                            ld_col_next = ld_col_reg + COL_W'(1);
                    end
                end
            end

            ST_CEN:
            begin
                mem_raddr  = sw_addr_reg;
                state_next = ST_UP;
            end

            ST_UP:
            begin
                mem_raddr  = n1_addr;
                state_next = ST_SIDE;
            end

            ST_SIDE:
            begin
                mem_raddr  = n2_addr;
                state_next = ST_WB;
            end

            ST_WB:
            begin
                // write back the copied label, then move on
                mem_we    = wb_change;
                mem_waddr = sw_addr_reg;
                mem_wdata = '{ridge: 1'b0,
                              label: q2 ? rd_data_reg.label : n1_reg.label};
                mem_raddr = sw_addr_step;
                if (!(col_end && row_end))
                begin
                    sw_row_next  = sw_row_step;
                    sw_col_next  = sw_col_step;
                    sw_addr_next = sw_addr_step;
                    changed_next = changed_reg | wb_change;
                    state_next   = ST_UP;
                end
                else if (!rev_reg && rev_ok)
                begin
                    rev_next     = 1'b1;
                    sw_row_next  = rows_reg - ROW_W'(3);
                    sw_col_next  = cols_reg - COL_W'(3);
                    sw_addr_next = sw_addr_reg - cols_ext - ADDR_W'(1);
                    changed_next = changed_reg | wb_change;
                    state_next   = ST_CEN;
                end
                else if (!(changed_reg | wb_change) || pass_left_reg == PASS_W'(1))
                    state_next = ST_READ;
                else
                begin
                    pass_left_next = pass_left_reg - PASS_W'(1);
                    changed_next   = 1'b0;
                    rev_next       = 1'b0;
                    sw_row_next    = ROW_W'(1);
                    sw_col_next    = COL_W'(1);
                    sw_addr_next   = fwd_start_addr;
                    state_next     = ST_CEN;
                end
            end

            ST_READ:
            begin
                mem_raddr = rd_addr_reg;
                if (accept && cmd == CMD_READ)
                begin
                    result_valid_next = 1'b1;
                    out_last_next     = rd_last;
                    if (rd_last)
                    begin
                        rd_row_next  = '0;
                        rd_col_next  = '0;
                        rd_addr_next = '0;
                        ld_row_next  = '0;
                        ld_col_next  = '0;
                        ld_addr_next = '0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + ADDR_W'(1);
                        if (rd_col_reg == cols_reg - COL_W'(1))
                        begin
                            rd_col_next = '0;
                            rd_row_next = rd_row_reg + ROW_W'(1);
                        end
                        else
                            rd_col_next = rd_col_reg + COL_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // a write to rows, cols or passes restarts the block
        if (cfg_fire &&
            (cfg_index == CFG_NUM_ROWS || cfg_index == CFG_NUM_COLS ||
             cfg_index == CFG_NUM_PASSES))
        begin
            if (cfg_index == CFG_NUM_ROWS)
                rows_next = size_rows;
            if (cfg_index == CFG_NUM_COLS)
                cols_next = size_cols;
            if (cfg_index == CFG_NUM_PASSES)
                passes_next = cfg_data[PASS_W-1:0];
            state_next   = ST_LOAD;
            ld_row_next  = '0;
            ld_col_next  = '0;
            ld_addr_next = '0;
            rd_row_next  = '0;
            rd_col_next  = '0;
            rd_addr_next = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            rows_reg         <= ROW_W'(RESET_ROWS);
            cols_reg         <= COL_W'(RESET_COLS);
            passes_reg       <= PASS_W'(RESET_PASSES);
            ld_row_reg       <= '0;
            ld_col_reg       <= '0;
            ld_addr_reg      <= '0;
            rd_row_reg       <= '0;
            rd_col_reg       <= '0;
            rd_addr_reg      <= '0;
            sw_row_reg       <= '0;
            sw_col_reg       <= '0;
            sw_addr_reg      <= '0;
            rev_reg          <= 1'b0;
            changed_reg      <= 1'b0;
            pass_left_reg    <= '0;
            result_valid_reg <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rows_reg         <= rows_next;
            cols_reg         <= cols_next;
            passes_reg       <= passes_next;
            ld_row_reg       <= ld_row_next;
            ld_col_reg       <= ld_col_next;
            ld_addr_reg      <= ld_addr_next;
            rd_row_reg       <= rd_row_next;
            rd_col_reg       <= rd_col_next;
            rd_addr_reg      <= rd_addr_next;
            sw_row_reg       <= sw_row_next;
            sw_col_reg       <= sw_col_next;
            sw_addr_reg      <= sw_addr_next;
            rev_reg          <= rev_next;
            changed_reg      <= changed_next;
            pass_left_reg    <= pass_left_next;
            result_valid_reg <= result_valid_next;
            out_last_reg     <= out_last_next;
        end
    end

    // capture center and row neighbor as they come back from memory
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UP)
            center_reg <= rd_data_reg;
        if (state_reg == ST_SIDE)
            n1_reg <= rd_data_reg;
    end

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

endmodule

// ===== bench/basin_fill_tracker_pkg.sv =====
// basin_fill_tracker_pkg: raster store mirror and expected readout labels for the label fill bench
// depends on rblf_pkg (sizes, register indexes, cell word); used by tb_raster_basin_label_fill
package basin_fill_tracker_pkg;

    import rblf_pkg::*;

    // one expected readout beat
    typedef struct {
        logic signed [LABEL_W-1:0] label;
        logic                      last;
    } label_beat_t;

    class basin_fill_tracker;

        // register copies, raw as written
        int unsigned raw_rows;
        int unsigned raw_cols;
        int unsigned passes;

        // raster walk state
        int unsigned load_ptr;
        int unsigned read_ptr;
        bit          reading;
        cell_word_t  cells [STORE_DEPTH];

        label_beat_t pending_labels [$];
        int unsigned mismatches;

        function new();
            raw_rows = RESET_ROWS;
            raw_cols = RESET_COLS;
            passes = RESET_PASSES;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            load_ptr = 0;
            read_ptr = 0;
            reading = 1'b0;
        endfunction

        // a written size of zero counts as one, anything above the limit as the limit
        function int unsigned clamp_size(int unsigned raw, int unsigned limit);
            if (raw == 0)
            begin
                return 1;
            end
            if (raw > limit)
            begin
                return limit;
            end
            return raw;
        endfunction

        function int unsigned row_count();
            return clamp_size(raw_rows, MAX_ROWS);
        endfunction

        function int unsigned col_count();
            return clamp_size(raw_cols, MAX_COLS);
        endfunction

        function int unsigned cell_count();
            return row_count() * col_count();
        endfunction

        // any known register write puts the block back to loading
        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_NUM_ROWS:   raw_rows = data[SIZE_W-1:0];
                CFG_NUM_COLS:   raw_cols = data[SIZE_W-1:0];
                CFG_NUM_PASSES: passes = data[PASS_W-1:0];
                default:        return;
            endcase
            restart();
        endfunction

        // a neighbor feeds its label only when labeled and not a ridge
        function bit can_feed(int unsigned src);
            return (cells[src].label != '0) && !cells[src].ridge;
        endfunction

        function bit fill_from(int unsigned dst, int unsigned src);
            if (can_feed(src))
            begin
                cells[dst].label = cells[src].label;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // forward sweep from upper/left, reverse sweep from lower/right
        function bit sweep_pair(int unsigned rows, int unsigned cols);
            bit          changed;
            int unsigned k;
            changed = 1'b0;
            if (rows >= 3 && cols >= 3)
            begin
                for (int unsigned r = 1; r < rows - 1; r++)
                begin
                    for (int unsigned c = 1; c < cols - 1; c++)
                    begin
                        k = r * cols + c;
                        if (cells[k].label == '0 && !cells[k].ridge)
                        begin
                            if (fill_from(k, k - cols)) changed = 1'b1;
                            if (fill_from(k, k - 1)) changed = 1'b1;
                        end
                    end
                end
            end
            if (rows >= 5 && cols >= 5)
            begin
                for (int r = int'(rows) - 3; r > 1; r--)
                begin
                    for (int c = int'(cols) - 3; c > 1; c--)
                    begin
                        k = int'(r) * cols + int'(c);
                        if (cells[k].label == '0 && !cells[k].ridge)
                        begin
                            if (fill_from(k, k + cols)) changed = 1'b1;
                            if (fill_from(k, k + 1)) changed = 1'b1;
                        end
                    end
                end
            end
            return changed;
        endfunction

        // ridge masking, then sweep pairs until the count runs out or nothing moves
        function void fill_basins();
            int unsigned rows;
            int unsigned cols;
            rows = row_count();
            cols = col_count();
            for (int unsigned k = 0; k < rows * cols; k++)
            begin
                if (cells[k].ridge) cells[k].label = '0;
            end
            for (int unsigned p = 0; p < passes; p++)
            begin
                if (!sweep_pair(rows, cols)) break;
            end
        endfunction

        // accepted command beat
        function void note_cell_beat(logic op, logic signed [LABEL_W-1:0] lab, logic rdg);
            int unsigned total;
            label_beat_t beat;
            total = cell_count();
            if (op == CMD_LOAD)
            begin
                if (reading) return;
                cells[load_ptr].label = lab;
                cells[load_ptr].ridge = rdg;
                load_ptr++;
                if (load_ptr >= total)
                begin
                    fill_basins();
                    read_ptr = 0;
                    reading = 1'b1;
                end
            end
            else
            begin
                if (!reading) return;
                beat.label = cells[read_ptr].label;
                beat.last = (read_ptr + 1 >= total);
                pending_labels.push_back(beat);
                if (beat.last) restart();
                else read_ptr++;
            end
        endfunction

        // result beat against the oldest expected label
        function void check_label_beat(logic signed [LABEL_W-1:0] lab, logic last);
            label_beat_t want;
            if (pending_labels.size() == 0)
            begin
                $error("result with no read waiting: out_label %0d out_last %0b", lab, last);
                mismatches++;
                return;
            end
            want = pending_labels.pop_front();
            if (lab !== want.label)
            begin
                $error("out_label: expected %0d, actual %0d", want.label, lab);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("out_last: expected %0b, actual %0b", want.last, last);
                mismatches++;
            end
        endfunction

        function bit report_clean();
            if (pending_labels.size() != 0)
            begin
                $error("%0d read beats never answered", pending_labels.size());
                mismatches++;
            end
            return mismatches == 0;
        endfunction

    endclass

endpackage

// ===== bench/tb_raster_basin_label_fill.sv =====
// tb_raster_basin_label_fill: random and directed raster loads, sweeps and readouts, checked
// against the label mirror; depends on rblf_pkg, basin_fill_tracker_pkg, raster_basin_label_fill
module tb_raster_basin_label_fill;

    timeunit 1ns;
    timeprecision 1ps;

    import rblf_pkg::*;
    import basin_fill_tracker_pkg::*;

    localparam int unsigned RANDOM_BEATS   = 1100;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam int unsigned WATCHDOG_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      cmd = CMD_LOAD;
    logic signed [LABEL_W-1:0] cell_label = '0;
    logic                      cell_ridge = 1'b0;
    logic                      result_valid;
    logic signed [LABEL_W-1:0] out_label;
    logic                      out_last;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    basin_fill_tracker tracker = new();
    reg_write_t        reg_writes [$];
    int unsigned       idle_pct = 35;
    int unsigned       beats_sent = 0;
    int unsigned       quiet_cycles = 0;
    bit                restart_due = 1'b0;

    raster_basin_label_fill dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cell_label   (cell_label),
        .cell_ridge   (cell_ridge),
        .result_valid (result_valid),
        .out_label    (out_label),
        .out_last     (out_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // accepted beats on all three channels, plus the quiet-cycle count
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            tracker.note_cell_beat(cmd, cell_label, cell_ridge);
        end
        if (rst_n && result_valid)
        begin
            tracker.check_label_beat(out_label, out_last);
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            tracker.apply_register(cfg_index, cfg_data);
        end
        if (rst_n && ((start && !busy) || result_valid || (cfg_valid && cfg_ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    // one command beat, with random idle cycles ahead of it
    task automatic send_beat(input logic op, input logic signed [LABEL_W-1:0] lab,
                             input logic rdg);
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= op;
        cell_label <= lab;
        cell_ridge <= rdg;
        do @(posedge clk); while (busy);
    endtask

    // beat the block does not act on in its current phase
    task automatic send_stray(input logic op);
        send_beat(op, $urandom, 1'($urandom));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending_labels.size() != 0) @(posedge clk);
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        reg_write_t w;
        w.idx = idx;
        w.data = val;
        reg_writes.push_back(w);
    endtask

    // block is quiet: results drained, sweeps done, a short settle, then the queued writes
    task automatic flush_register_writes();
        wait_drained();
        while (busy) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (reg_writes.size() != 0)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_writes[0].idx;
            cfg_data <= reg_writes[0].data;
            void'(reg_writes.pop_front());
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [LABEL_W-1:0] pick_label();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 50) return '0;
        if (roll < 54) return 32'sh7fffffff;
        if (roll < 58) return 32'sh80000000;
        if (roll < 62) return -32'sd1;
        return $urandom;
    endfunction

    // size with junk in the bits above the register width
    function automatic logic [CFG_DATA_W-1:0] pick_size();
        int unsigned roll;
        logic [SIZE_W-1:0] sz;
        roll = $urandom_range(99, 0);
        if (roll < 8) sz = '0;
        else if (roll < 16) sz = SIZE_W'($urandom_range(2, 1));
        else sz = SIZE_W'($urandom_range(12, 3));
        return {6'($urandom), sz};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_passes();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 10) return '0;
        if (roll < 40) return 16'd1;
        if (roll < 80) return 16'($urandom_range(6, 2));
        return 16'hffff;
    endfunction

    // one raster: loads with stray reads, then readout with stray loads;
    // sometimes cut short, which calls for a register write before the next one
    task automatic run_raster(input bit may_cut);
        int unsigned total;
        int unsigned cut_at;
        int unsigned pause_at;
        total = tracker.cell_count();
        cut_at = total;
        if (may_cut && $urandom_range(11, 0) == 0) cut_at = $urandom_range(total - 1, 0);
        for (int unsigned k = 0; k < total; k++)
        begin
            if (k == cut_at)
            begin
                restart_due = 1'b1;
                return;
            end
            if ($urandom_range(19, 0) == 0) send_stray(CMD_READ);
            send_beat(CMD_LOAD, pick_label(), $urandom_range(99, 0) < 20);
            beats_sent++;
        end
        cut_at = total;
        if (may_cut && $urandom_range(11, 0) == 0) cut_at = $urandom_range(total - 1, 0);
        pause_at = ($urandom_range(3, 0) == 0) ? $urandom_range(total - 1, 0) : total;
        for (int unsigned k = 0; k < total; k++)
        begin
            if (k == cut_at)
            begin
                restart_due = 1'b1;
                return;
            end
            if (k == pause_at) wait_drained();
            if ($urandom_range(19, 0) == 0) send_stray(CMD_LOAD);
            send_beat(CMD_READ, $urandom, 1'($urandom));
            beats_sent++;
        end
    endtask

    initial
    begin
        int unsigned phase_no;

        // reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two-cell strip: zero row count, extreme labels, ridge clearing, ignored beats
        queue_write(CFG_NUM_ROWS, 16'd0);
        queue_write(CFG_NUM_COLS, 16'd2);
        queue_write(CFG_NUM_PASSES, 16'd0);
        flush_register_writes();
        send_beat(CMD_READ, 32'sd17, 1'b1);
        send_beat(CMD_LOAD, 32'sh80000000, 1'b0);
        send_beat(CMD_LOAD, 32'sh7fffffff, 1'b1);
        send_beat(CMD_LOAD, -32'sd1, 1'b0);
        send_beat(CMD_READ, '0, 1'b0);
        send_beat(CMD_READ, '0, 1'b0);

        // 3x3: upper and left neighbors both qualify, the left one wins;
        // an unknown register index mid-load must not restart the load
        queue_write(CFG_NUM_ROWS, 16'd3);
        queue_write(CFG_NUM_COLS, 16'd3);
        queue_write(CFG_NUM_PASSES, 16'hffff);
        flush_register_writes();
        send_beat(CMD_LOAD, 32'sd11, 1'b0);
        send_beat(CMD_LOAD, 32'sd7, 1'b0);
        send_beat(CMD_LOAD, '0, 1'b1);
        send_beat(CMD_LOAD, 32'sd9, 1'b0);
        queue_write(CFG_UNUSED, 16'hffff);
        flush_register_writes();
        send_beat(CMD_LOAD, '0, 1'b0);
        send_beat(CMD_LOAD, -32'sd5, 1'b1);
        send_beat(CMD_LOAD, '0, 1'b0);
        send_beat(CMD_LOAD, 32'sh7fffffff, 1'b1);
        send_beat(CMD_LOAD, 32'sd1, 1'b0);
        for (int k = 0; k < 9; k++)
        begin
            if (k == 4) wait_drained();
            send_beat(CMD_READ, '0, 1'b0);
        end

        // largest row count with junk above the register width, zero columns;
        // the whole raster streams with no idle cycles
        queue_write(CFG_NUM_ROWS, 16'hffff);
        queue_write(CFG_NUM_COLS, 16'hfc00);
        queue_write(CFG_NUM_PASSES, pick_passes());
        flush_register_writes();
        idle_pct = 0;
        run_raster(1'b0);
        idle_pct = 35;

        // random rasters until the beat budget is spent
        phase_no = 0;
        while (beats_sent < RANDOM_BEATS)
        begin
            idle_pct = (phase_no >= 2 && phase_no <= 5) ? 0 : 35;
            if (restart_due || $urandom_range(2, 0) != 0)
            begin
                if ($urandom_range(4, 0) != 0) queue_write(CFG_NUM_ROWS, pick_size());
                if ($urandom_range(4, 0) != 0) queue_write(CFG_NUM_COLS, pick_size());
                if ($urandom_range(2, 0) != 0 || reg_writes.size() == 0)
                    queue_write(CFG_NUM_PASSES, pick_passes());
                flush_register_writes();
                restart_due = 1'b0;
            end
            run_raster(1'b1);
            phase_no++;
        end

        // drain and report
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.report_clean())
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
